// File: sv/ite_pkg.sv
// Shared types and constants of the indexed table engine.
`timescale 1ns / 1ps

package ite_pkg;

	// Fixed field widths of the request and result transactions.
	localparam int KIND_W   = 3;
	localparam int INDEX_W  = 10;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 11;

	// Packed stream widths, padded to whole bytes.
	localparam int S_FIELDS_W = INDEX_W + VALUE_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int S_PAD_W    = S_TDATA_W - S_FIELDS_W;
	localparam int M_FIELDS_W = INDEX_W + 2 * VALUE_W + FILL_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	// Request kinds.
	typedef enum logic [KIND_W-1:0] {
		REQ_FIND   = 3'd0,
		REQ_MODIFY = 3'd1,
		REQ_ADD    = 3'd2,
		REQ_REMOVE = 3'd3,
		REQ_ZERO   = 3'd4
	} req_kind_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_RANGE    = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

endpackage

// File: sv/ite_ram.sv
// Single-port-write, single-port-read table memory with registered read data.
`timescale 1ns / 1ps

module ite_ram #(
	parameter int DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  logic [ite_pkg::VALUE_W-1:0]   wdata,
	input  logic                          re,
	input  logic [$clog2(DEPTH)-1:0]      raddr,
	output logic [ite_pkg::VALUE_W-1:0]   rdata
);

	logic [ite_pkg::VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/indexed_table_engine.sv
// Top level of the indexed table engine: request sequencer, fill count and result register.
`timescale 1ns / 1ps

// Channel   Dir  Signals                      Contents (lowest bit first)
// request   in   s_tvalid/s_tready/s_tdata    tdata: index[9:0], item_value[41:10], pad
//                s_tuser                      tuser: req_type[2:0]
// result    out  m_tvalid/m_tready/m_tdata    tdata: found_index[9:0], old_value[41:10],
//                m_tuser                        written_value[73:42], fill_count[84:74], pad
//                                             tuser: status[1:0]
//
// Add, zero, unknown kinds and out-of-range requests pass from acceptance through the
// response state into the result register; modify passes its write-back state first.
// Find and remove walk the table memory one entry per cycle through its single read
// port, find from entry 0 and remove from index + 1, both up to the fill count.
// Reset empties the table at once (fill count to zero); the memory is not
// cleared, since only entries below the fill count are ever read.
// A new request is accepted while an earlier result still waits on m_tready;
// a finished request holds in the response state until the result register frees.

module indexed_table_engine #(
	parameter int DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request transaction.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ite_pkg::S_TDATA_W-1:0]  s_tdata,  // index, item_value, zero pad
	input  logic [ite_pkg::KIND_W-1:0]     s_tuser,  // req_type
	// Result transaction.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ite_pkg::M_TDATA_W-1:0]  m_tdata,  // found_index, old_value, written_value,
	                                                 // fill_count, zero pad
	output logic [ite_pkg::STATUS_W-1:0]   m_tuser   // status
);

	// Address width of the memory, width of the fill count (it can reach DEPTH),
	// and a compare width that holds both the index field and the count.
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = (CW > ite_pkg::INDEX_W) ? CW : ite_pkg::INDEX_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_MOD_WR,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   ptr_q;
	logic [AW-1:0]                   addr_q;
	logic [ite_pkg::VALUE_W-1:0]     val_q;
	ite_pkg::status_t                status_q;
	logic [ite_pkg::INDEX_W-1:0]     found_q;
	logic [ite_pkg::VALUE_W-1:0]     old_q;
	logic [ite_pkg::VALUE_W-1:0]     new_q;
	logic                            rd_vld_s1;
	logic [AW-1:0]                   rd_idx_s1;
	logic                            m_tvalid_q;
	logic [ite_pkg::M_TDATA_W-1:0]   m_tdata_q;
	logic [ite_pkg::STATUS_W-1:0]    m_tuser_q;

	// Request fields and derived conditions.
	logic                            s_accept;
	ite_pkg::req_kind_t              in_kind;
	logic [ite_pkg::INDEX_W-1:0]     in_index;
	logic [ite_pkg::VALUE_W-1:0]     in_value;
	logic [CMP_W-1:0]                idx_ext;
	logic                            in_range;
	logic                            not_full;
	logic                            mod_miss;
	ite_pkg::status_t                in_status;
	logic                            more;
	logic                            match;
	logic                            issue;

	// Memory port.
	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [ite_pkg::VALUE_W-1:0]     ram_wdata;
	logic                            ram_re;
	logic [AW-1:0]                   ram_raddr;
	logic [ite_pkg::VALUE_W-1:0]     ram_rdata;

	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid & s_tready;
	assign in_kind  = ite_pkg::req_kind_t'(s_tuser);
	assign in_index = s_tdata[ite_pkg::INDEX_W-1:0];
	assign in_value = s_tdata[ite_pkg::INDEX_W +: ite_pkg::VALUE_W];
	assign idx_ext  = CMP_W'(in_index);
	assign in_range = idx_ext < CMP_W'(count_q);
	assign not_full = count_q < CW'(DEPTH);

	// A modify outside the table reports all ones as both old and written value.
	assign mod_miss = (in_kind == ite_pkg::REQ_MODIFY) && !in_range;

	// Status known at acceptance. A find starts as ok and turns to not found when its walk
	// ends without a match.
	always_comb begin
		in_status = ite_pkg::STAT_OK;
		unique case (in_kind)
			ite_pkg::REQ_MODIFY, ite_pkg::REQ_REMOVE, ite_pkg::REQ_ZERO: begin
				if (!in_range) begin
					in_status = ite_pkg::STAT_RANGE;
				end
			end
			ite_pkg::REQ_ADD: begin
				if (!not_full) begin
					in_status = ite_pkg::STAT_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	// Walks read one entry per cycle while the pointer is below the fill count.
	// The compare of the previous read runs in the same cycle; a find stops
	// issuing once it sees a match.
	assign more  = ptr_q < count_q;
	assign match = (state_q == S_FIND) && rd_vld_s1 && (ram_rdata == val_q);
	assign issue = ((state_q == S_FIND) && !match && more) ||
	               ((state_q == S_SHIFT) && more);

	// Memory control. A remove reads entry i + 1 while writing entry i, read in the
	// previous cycle, to i - 1, so the write always trails the read address and
	// no forwarding is needed. Modify reads at acceptance and writes back the
	// next cycle, with no other access to the table in between.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = val_q;
		if (s_accept) begin
			unique case (in_kind)
				ite_pkg::REQ_MODIFY: begin
					if (in_range) begin
						ram_re    = 1'b1;
						ram_raddr = idx_ext[AW-1:0];
					end
				end
				ite_pkg::REQ_ADD: begin
					if (not_full) begin
						ram_we    = 1'b1;
						ram_waddr = count_q[AW-1:0];
						ram_wdata = in_value;
					end
				end
				ite_pkg::REQ_ZERO: begin
					if (in_range) begin
						ram_we    = 1'b1;
						ram_waddr = idx_ext[AW-1:0];
						ram_wdata = '0;
					end
				end
				default: begin
				end
			endcase
		end else begin
			ram_re = issue;
			if (state_q == S_MOD_WR) begin
				ram_we = 1'b1;
			end else if ((state_q == S_SHIFT) && rd_vld_s1) begin
				ram_we    = 1'b1;
				ram_waddr = rd_idx_s1 - AW'(1);
				ram_wdata = ram_rdata;
			end
		end
	end

	ite_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer with the fill count and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			rd_idx_s1 <= ptr_q[AW-1:0];
			// The response state reloads the result register itself.
			if (m_tvalid_q && m_tready && (state_q != S_RESP)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						val_q    <= in_value;
						addr_q   <= idx_ext[AW-1:0];
						found_q  <= '0;
						old_q    <= {ite_pkg::VALUE_W{mod_miss}};
						new_q    <= {ite_pkg::VALUE_W{mod_miss}};
						status_q <= in_status;
						ptr_q    <= (in_kind == ite_pkg::REQ_REMOVE) ?
						            (CW'(idx_ext) + CW'(1)) : '0;
						unique case (in_kind)
							ite_pkg::REQ_FIND: begin
								state_q <= S_FIND;
							end
							ite_pkg::REQ_MODIFY: begin
								if (in_range) begin
									state_q <= S_MOD_WR;
								end else begin
									state_q <= S_RESP;
								end
							end
							ite_pkg::REQ_ADD: begin
								if (not_full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= S_RESP;
							end
							ite_pkg::REQ_REMOVE: begin
								if (in_range) begin
									state_q <= S_SHIFT;
								end else begin
									state_q <= S_RESP;
								end
							end
							ite_pkg::REQ_ZERO: begin
								state_q <= S_RESP;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_FIND: begin
					if (match) begin
						found_q <= ite_pkg::INDEX_W'(rd_idx_s1);
						state_q <= S_RESP;
					end else if (issue) begin
						ptr_q <= ptr_q + CW'(1);
					end else if (!rd_vld_s1) begin
						status_q <= ite_pkg::STAT_NOTFOUND;
						state_q  <= S_RESP;
					end
				end
				S_MOD_WR: begin
					old_q   <= ram_rdata;
					new_q   <= val_q;
					state_q <= S_RESP;
				end
				S_SHIFT: begin
					if (issue) begin
						ptr_q <= ptr_q + CW'(1);
					end else if (!rd_vld_s1) begin
						count_q <= count_q - CW'(1);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= status_q;
						m_tdata_q  <= {{ite_pkg::M_PAD_W{1'b0}},
						               ite_pkg::FILL_W'(count_q), new_q, old_q, found_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// The fill count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count exceeds table depth");

	// A successful add grows the fill count by exactly one.
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && (in_kind == ite_pkg::REQ_ADD) && not_full)
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("add did not grow the fill count");

	// Shifting writes stay inside the valid part of the table.
	a_shift_write: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SHIFT) && ram_we) |-> (CW'(ram_waddr) < count_q))
		else $error("shift write beyond the fill count");

	// A finished request whose result register is free shows its result next cycle.
	a_resp_out: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RESP) && (!m_tvalid_q || m_tready)) |=> (m_tvalid && s_tready))
		else $error("result not presented after response");

endmodule

// File: bench/indexed_table_engine_test.sv
// Self-checking stream testbench for the indexed table engine, with its own table predictor.
`timescale 1ns / 1ps

module indexed_table_engine_test;

	localparam int DEPTH = 1024;

	// Bit positions of the result fields inside m_tdata.
	localparam int OLD_LSB  = ite_pkg::INDEX_W;
	localparam int NEW_LSB  = ite_pkg::INDEX_W + ite_pkg::VALUE_W;
	localparam int FILL_LSB = ite_pkg::INDEX_W + 2 * ite_pkg::VALUE_W;

	// Request kinds that the block does not decode. They must leave the table alone.
	localparam logic [ite_pkg::KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
	localparam logic [ite_pkg::KIND_W-1:0] KIND_SPARE_MID = 3'd6;
	localparam logic [ite_pkg::KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

	// Marker written into the last slot when the table is filled, so that a find has to
	// walk every entry before it hits.
	localparam logic [ite_pkg::VALUE_W-1:0] TAIL_MARK = 32'h5A5A_C3C3;

	localparam int RAND_ITEMS   = 580;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_WAIT  = DEPTH + 8;
	localparam int CYCLE_LIMIT  = 1000000;

	// One result transaction as the predictor sees it.
	typedef struct {
		ite_pkg::status_t            status;
		logic [ite_pkg::INDEX_W-1:0] found;
		logic [ite_pkg::VALUE_W-1:0] old_value;
		logic [ite_pkg::VALUE_W-1:0] new_value;
		logic [ite_pkg::FILL_W-1:0]  fill;
	} table_result_t;

	// One row of the directed stimulus. Rows with a typed result carry it in want.
	typedef struct {
		logic [ite_pkg::KIND_W-1:0]  kind;
		logic [ite_pkg::INDEX_W-1:0] idx;
		logic [ite_pkg::VALUE_W-1:0] val;
		bit                          typed;
		table_result_t               want;
	} request_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [ite_pkg::S_TDATA_W-1:0]  s_tdata;   // index[9:0], item_value[41:10], zero pad
	logic [ite_pkg::KIND_W-1:0]     s_tuser;   // req_type[2:0]
	logic                           m_tvalid;
	logic                           m_tready;
	logic [ite_pkg::M_TDATA_W-1:0]  m_tdata;   // found_index[9:0], old_value[41:10],
	                                           // written_value[73:42], fill_count[84:74],
	                                           // zero pad
	logic [ite_pkg::STATUS_W-1:0]   m_tuser;   // status[1:0]

	// Predictor state: the table contents and the fill count as the block should hold them.
	logic [ite_pkg::VALUE_W-1:0]    table_mem [DEPTH];
	logic [ite_pkg::FILL_W-1:0]     table_count;

	// Results predicted at request acceptance, oldest first.
	table_result_t         pending_results [$];
	request_row_t          directed_rows [$];

	int                    send_idle_pct;
	int                    recv_idle_pct;
	bit                    hold_req;
	int                    fail_count;
	int                    cycle_count;
	int                    kind_seen [8];
	int                    status_seen [4];

	indexed_table_engine #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog. A hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Applies one request to the predictor's table and returns the result the block owes.
	// Only entries below the fill count are ever read, so unwritten slots never matter.
	function automatic table_result_t apply_request(input logic [ite_pkg::KIND_W-1:0] kind,
			input logic [ite_pkg::INDEX_W-1:0] idx, input logic [ite_pkg::VALUE_W-1:0] val);
		table_result_t res;
		bit            hit;
		bit            in_range;
		int            i;
		res.status    = ite_pkg::STAT_OK;
		res.found     = '0;
		res.old_value = '0;
		res.new_value = '0;
		in_range      = ({1'b0, idx} < table_count);
		hit           = 1'b0;
		case (kind)
			ite_pkg::REQ_FIND: begin
				res.status = ite_pkg::STAT_NOTFOUND;
				for (i = 0; i < int'(table_count); i++) begin
					if (!hit && table_mem[i] == val) begin
						hit        = 1'b1;
						res.status = ite_pkg::STAT_OK;
						res.found  = i[ite_pkg::INDEX_W-1:0];
					end
				end
			end
			ite_pkg::REQ_MODIFY: begin
				if (in_range) begin
					res.old_value  = table_mem[idx];
					table_mem[idx] = val;
					res.new_value  = val;
				end else begin
					res.status    = ite_pkg::STAT_RANGE;
					res.old_value = '1;
					res.new_value = '1;
				end
			end
			ite_pkg::REQ_ADD: begin
				if (int'(table_count) >= DEPTH) begin
					res.status = ite_pkg::STAT_FULL;
				end else begin
					table_mem[table_count] = val;
					table_count            = table_count + 1'b1;
				end
			end
			ite_pkg::REQ_REMOVE: begin
				if (in_range) begin
					// Everything above the removed slot moves down one place.
					for (i = int'(idx); i + 1 < int'(table_count); i++) begin
						table_mem[i] = table_mem[i + 1];
					end
					table_count = table_count - 1'b1;
				end else begin
					res.status = ite_pkg::STAT_RANGE;
				end
			end
			ite_pkg::REQ_ZERO: begin
				if (in_range) begin
					table_mem[idx] = '0;
				end else begin
					res.status = ite_pkg::STAT_RANGE;
				end
			end
			default: begin
			end
		endcase
		res.fill = table_count;
		return res;
	endfunction

	// Offers one request transaction, holds it until the block takes it, and then records
	// what the block must answer. A typed result from the directed table takes the place of
	// the prediction, but the predictor still sees the request so its table stays in step.
	task automatic send_request(input logic [ite_pkg::KIND_W-1:0] kind,
			input logic [ite_pkg::INDEX_W-1:0] idx, input logic [ite_pkg::VALUE_W-1:0] val,
			input bit typed, input table_result_t want);
		table_result_t got;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{ite_pkg::S_PAD_W{1'b0}}, val, idx};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		got = apply_request(kind, idx, val);
		pending_results.push_back(typed ? want : got);
		kind_seen[kind]++;
	endtask

	task automatic add_row(input logic [ite_pkg::KIND_W-1:0] kind,
			input logic [ite_pkg::INDEX_W-1:0] idx, input logic [ite_pkg::VALUE_W-1:0] val,
			input bit typed, input ite_pkg::status_t st,
			input logic [ite_pkg::INDEX_W-1:0] found, input logic [ite_pkg::VALUE_W-1:0] oldv,
			input logic [ite_pkg::VALUE_W-1:0] newv, input logic [ite_pkg::FILL_W-1:0] fill);
		request_row_t row;
		row.kind           = kind;
		row.idx            = idx;
		row.val            = val;
		row.typed          = typed;
		row.want.status    = st;
		row.want.found     = found;
		row.want.old_value = oldv;
		row.want.new_value = newv;
		row.want.fill      = fill;
		directed_rows.push_back(row);
	endtask

	// Compares one accepted result transaction, field by field, with the oldest prediction.
	task automatic check_result();
		table_result_t               want;
		logic [ite_pkg::INDEX_W-1:0] got_found;
		logic [ite_pkg::VALUE_W-1:0] got_old;
		logic [ite_pkg::VALUE_W-1:0] got_new;
		logic [ite_pkg::FILL_W-1:0]  got_fill;
		got_found = m_tdata[ite_pkg::INDEX_W-1:0];
		got_old   = m_tdata[OLD_LSB +: ite_pkg::VALUE_W];
		got_new   = m_tdata[NEW_LSB +: ite_pkg::VALUE_W];
		got_fill  = m_tdata[FILL_LSB +: ite_pkg::FILL_W];
		status_seen[m_tuser]++;
		if (pending_results.size() == 0) begin
			$error("result transaction with no request waiting: status %0d fill %0d",
				m_tuser, got_fill);
			fail_count++;
		end else begin
			want = pending_results.pop_front();
			if (m_tuser !== want.status) begin
				$error("status expected %0d got %0d", want.status, m_tuser);
				fail_count++;
			end
			if (got_found !== want.found) begin
				$error("found_index expected %0d got %0d", want.found, got_found);
				fail_count++;
			end
			if (got_old !== want.old_value) begin
				$error("old_value expected %0d got %0d", $signed(want.old_value),
					$signed(got_old));
				fail_count++;
			end
			if (got_new !== want.new_value) begin
				$error("written_value expected %0d got %0d", $signed(want.new_value),
					$signed(got_new));
				fail_count++;
			end
			if (got_fill !== want.fill) begin
				$error("fill_count expected %0d got %0d", want.fill, got_fill);
				fail_count++;
			end
		end
	endtask

	// Result side. Each edge first checks a completed transaction, then picks the ready
	// level for the next cycle. When the stimulus asks for back pressure, ready stays low
	// for a counted stretch so the block fills up and has to stall its request side.
	initial begin
		int hold_left;
		bit hold_done;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				check_result();
			end
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) begin
					@(posedge clk);
				end
				hold_done = 1'b1;
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Request side and run control.
	initial begin
		table_result_t               blank;
		request_row_t                row;
		logic [ite_pkg::KIND_W-1:0]  rk;
		logic [ite_pkg::INDEX_W-1:0] ri;
		logic [ite_pkg::VALUE_W-1:0] rv;
		int                          n;
		int                          r;
		int                          cnt;
		int                          add_w;
		int                          rem_w;

		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		hold_req      = 1'b0;
		fail_count    = 0;
		send_idle_pct = 19;
		recv_idle_pct = 73;
		table_count   = '0;
		blank.status    = ite_pkg::STAT_OK;
		blank.found     = '0;
		blank.old_value = '0;
		blank.new_value = '0;
		blank.fill      = '0;
		for (n = 0; n < 8; n++) begin
			kind_seen[n] = 0;
		end
		for (n = 0; n < 4; n++) begin
			status_seen[n] = 0;
		end

		// Directed table. Rows marked 1 carry a result that follows directly from the
		// request; rows marked 0 go through the predictor.
		// Empty table: nothing can be found and every index is out of range.
		add_row(ite_pkg::REQ_FIND,   10'd0, 32'h0000_0000, 1, ite_pkg::STAT_NOTFOUND,
			0, 0, 0, 0);
		add_row(ite_pkg::REQ_MODIFY, 10'd0, 32'h0000_0005, 1, ite_pkg::STAT_RANGE,
			0, '1, '1, 0);
		add_row(ite_pkg::REQ_REMOVE, 10'd0, 32'h0000_0000, 1, ite_pkg::STAT_RANGE,
			0, 0, 0, 0);
		add_row(ite_pkg::REQ_ZERO,   10'd0, 32'h0000_0000, 1, ite_pkg::STAT_RANGE,
			0, 0, 0, 0);
		add_row(KIND_SPARE_LO, 10'd1023, 32'hFFFF_FFFF, 1, ite_pkg::STAT_OK, 0, 0, 0, 0);
		// Appends of the value extremes.
		add_row(ite_pkg::REQ_ADD,    10'd0,    32'h8000_0000, 1, ite_pkg::STAT_OK,
			0, 0, 0, 1);
		add_row(ite_pkg::REQ_ADD,    10'd1023, 32'h7FFF_FFFF, 1, ite_pkg::STAT_OK,
			0, 0, 0, 2);
		add_row(ite_pkg::REQ_ADD,    10'd0,    32'h0000_0000, 1, ite_pkg::STAT_OK,
			0, 0, 0, 3);
		add_row(ite_pkg::REQ_ADD,    10'd0,    32'hFFFF_FFFF, 1, ite_pkg::STAT_OK,
			0, 0, 0, 4);
		add_row(ite_pkg::REQ_FIND,   10'd0,    32'h7FFF_FFFF, 1, ite_pkg::STAT_OK,
			1, 0, 0, 4);
		add_row(ite_pkg::REQ_FIND,   10'd0,    32'h8000_0000, 1, ite_pkg::STAT_OK,
			0, 0, 0, 4);
		add_row(ite_pkg::REQ_FIND,   10'd0,    32'h0000_3039, 1, ite_pkg::STAT_NOTFOUND,
			0, 0, 0, 4);
		add_row(ite_pkg::REQ_MODIFY, 10'd3,    32'h7FFF_FFFF, 1, ite_pkg::STAT_OK,
			0, '1, 32'h7FFF_FFFF, 4);
		// A duplicate value must report its lowest index.
		add_row(ite_pkg::REQ_FIND,   10'd0,    32'h7FFF_FFFF, 0, ite_pkg::STAT_OK,
			0, 0, 0, 0);
		// Index equal to the fill count is just out of range.
		add_row(ite_pkg::REQ_MODIFY, 10'd4,    32'h1234_5678, 1, ite_pkg::STAT_RANGE,
			0, '1, '1, 4);
		add_row(ite_pkg::REQ_ZERO,   10'd1,    32'h0000_0000, 0, ite_pkg::STAT_OK,
			0, 0, 0, 0);
		add_row(ite_pkg::REQ_FIND,   10'd0,    32'h0000_0000, 0, ite_pkg::STAT_OK,
			0, 0, 0, 0);
		add_row(ite_pkg::REQ_REMOVE, 10'd0,    32'h0000_0000, 0, ite_pkg::STAT_OK,
			0, 0, 0, 0);
		add_row(ite_pkg::REQ_FIND,   10'd0,    32'h7FFF_FFFF, 0, ite_pkg::STAT_OK,
			0, 0, 0, 0);
		add_row(ite_pkg::REQ_REMOVE, 10'd2,    32'h0000_0000, 0, ite_pkg::STAT_OK,
			0, 0, 0, 0);
		add_row(ite_pkg::REQ_ZERO,   10'd1023, 32'h0000_0000, 1, ite_pkg::STAT_RANGE,
			0, 0, 0, 2);
		add_row(ite_pkg::REQ_MODIFY, 10'd1023, 32'h0000_0000, 1, ite_pkg::STAT_RANGE,
			0, '1, '1, 2);
		add_row(KIND_SPARE_HI,  10'd0,   32'h0000_0000, 1, ite_pkg::STAT_OK, 0, 0, 0, 2);
		add_row(KIND_SPARE_MID, 10'd512, 32'hA5A5_A5A5, 0, ite_pkg::STAT_OK, 0, 0, 0, 0);
		add_row(ite_pkg::REQ_REMOVE, 10'd3,    32'h0000_0000, 1, ite_pkg::STAT_RANGE,
			0, 0, 0, 2);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			row = directed_rows[n];
			send_request(row.kind, row.idx, row.val, row.typed, row.want);
		end

		// Fill the table to capacity with back-to-back appends, then hit the full table,
		// the longest find and the longest shift, and drain it from the top.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (int'(table_count) < DEPTH - 1) begin
			send_request(ite_pkg::REQ_ADD, 10'($urandom_range(1023)), $urandom, 0, blank);
		end
		send_request(ite_pkg::REQ_ADD, 10'd0, TAIL_MARK, 0, blank);
		send_request(ite_pkg::REQ_ADD, 10'd0, 32'h0BAD_F00D, 0, blank);
		send_request(ite_pkg::REQ_FIND, 10'd0, TAIL_MARK, 0, blank);
		send_request(ite_pkg::REQ_MODIFY, 10'd1023, 32'h8000_0000, 0, blank);
		send_request(ite_pkg::REQ_FIND, 10'd0, 32'h8000_0000, 0, blank);
		send_request(ite_pkg::REQ_REMOVE, 10'd0, 32'h0000_0000, 0, blank);
		send_request(ite_pkg::REQ_ADD, 10'd0, 32'h7FFF_FFFF, 0, blank);
		send_request(ite_pkg::REQ_ZERO, 10'd1023, 32'h0000_0000, 0, blank);
		send_request(ite_pkg::REQ_MODIFY, 10'd1023, 32'hFFFF_FFFF, 0, blank);
		while (int'(table_count) > 8) begin
			send_request(ite_pkg::REQ_REMOVE, 10'(int'(table_count) - 1), $urandom, 0,
				blank);
		end

		// Random part, in three thirds with different idling. The mix leans toward
		// removes when the table grows, so finds and shifts stay short.
		n = 0;
		while (n < RAND_ITEMS) begin
			if (n == 0) begin
				send_idle_pct = 19;
				recv_idle_pct = 73;
			end else if (n == RAND_ITEMS / 3) begin
				send_idle_pct = 73;
				recv_idle_pct = 19;
			end else if (n == 2 * RAND_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_req      = 1'b1;
			end
			cnt   = int'(table_count);
			add_w = (cnt < 8) ? 45 : ((cnt > 48) ? 10 : 28);
			rem_w = (cnt > 48) ? 35 : 14;
			r     = $urandom_range(99);
			if (r < 4) begin
				rk = KIND_SPARE_LO + 3'($urandom_range(2));
			end else if (r < 4 + add_w) begin
				rk = ite_pkg::REQ_ADD;
			end else if (r < 4 + add_w + rem_w) begin
				rk = ite_pkg::REQ_REMOVE;
			end else if (r < 24 + add_w + rem_w) begin
				rk = ite_pkg::REQ_FIND;
			end else if (r < 38 + add_w + rem_w) begin
				rk = ite_pkg::REQ_MODIFY;
			end else begin
				rk = ite_pkg::REQ_ZERO;
			end
			if (cnt != 0 && $urandom_range(99) < 85) begin
				ri = 10'($urandom_range(cnt - 1));
			end else begin
				ri = 10'($urandom_range(1023));
			end
			// Values often repeat table contents so finds hit, with the extremes mixed in.
			r = $urandom_range(9);
			if (r < 4 && cnt != 0) begin
				rv = table_mem[$urandom_range(cnt - 1)];
			end else if (r == 4) begin
				rv = 32'h0000_0000;
			end else if (r == 5) begin
				rv = 32'h7FFF_FFFF;
			end else if (r == 6) begin
				rv = 32'h8000_0000;
			end else if (r == 7) begin
				rv = 32'hFFFF_FFFF;
			end else begin
				rv = $urandom;
			end
			send_request(rk, ri, rv, 0, blank);
			if (rk <= ite_pkg::REQ_ZERO) begin
				n++;
			end
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_WAIT) @(posedge clk);

		$display("Requests: find %0d, modify %0d, add %0d, remove %0d, zero %0d, undecoded %0d.",
			kind_seen[ite_pkg::REQ_FIND], kind_seen[ite_pkg::REQ_MODIFY],
			kind_seen[ite_pkg::REQ_ADD], kind_seen[ite_pkg::REQ_REMOVE],
			kind_seen[ite_pkg::REQ_ZERO],
			kind_seen[KIND_SPARE_LO] + kind_seen[KIND_SPARE_MID] + kind_seen[KIND_SPARE_HI]);
		$display("Results: ok %0d, out of range %0d, full %0d, not found %0d; %0d mismatches.",
			status_seen[ite_pkg::STAT_OK], status_seen[ite_pkg::STAT_RANGE],
			status_seen[ite_pkg::STAT_FULL], status_seen[ite_pkg::STAT_NOTFOUND], fail_count);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
